[design/joystick_stepper_process_sequencer_macros.svh]
// Assertion macros for the joystick stepper process sequencer.
// Included by the top level; depends on nothing else.
`ifndef JOYSTICK_STEPPER_PROCESS_SEQUENCER_MACROS_SVH
`define JOYSTICK_STEPPER_PROCESS_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

[design/jsps_pkg.sv]
// Shared types, phase codes and register indexes of the joystick stepper sequencer.
// Depends on nothing; imported by jsps_step, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package jsps_pkg;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned PH_W  = 5;

    localparam logic [CNT_W-1:0] CNT_MAX           = '1;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET    = 16'd50;
    localparam logic [CNT_W-1:0] PHASE_TICKS_RESET = 16'd5000;

    // Configuration register indexes.
    localparam logic CFG_DEBOUNCE    = 1'b0;
    localparam logic CFG_PHASE_TICKS = 1'b1;

    // Phase codes.
    localparam logic [PH_W-1:0] PH_IDLE          = 5'd0;
    localparam logic [PH_W-1:0] PH_PLACEMENT     = 5'd1;
    localparam logic [PH_W-1:0] PH_LOWERING      = 5'd2;
    localparam logic [PH_W-1:0] PH_STIRRING      = 5'd3;
    localparam logic [PH_W-1:0] PH_MEASURE       = 5'd4;
    localparam logic [PH_W-1:0] PH_MEASURE_READY = 5'd5;
    localparam logic [PH_W-1:0] PH_DISPLAY       = 5'd6;
    localparam logic [PH_W-1:0] PH_REMOVAL       = 5'd7;
    localparam logic [PH_W-1:0] PH_SAMPLE_X      = 5'd8;
    localparam logic [PH_W-1:0] PH_SAMPLE_Y      = 5'd9;
    localparam logic [PH_W-1:0] PH_CLEANING      = 5'd10;
    localparam logic [PH_W-1:0] PH_CLEAN_Y       = 5'd11;
    localparam logic [PH_W-1:0] PH_CLEAN_X       = 5'd12;
    localparam logic [PH_W-1:0] PH_CLEAN_Y2      = 5'd13;
    localparam logic [PH_W-1:0] PH_DRYING        = 5'd14;
    localparam logic [PH_W-1:0] PH_DRY_Y         = 5'd15;
    localparam logic [PH_W-1:0] PH_DRY_X         = 5'd16;
    localparam logic [PH_W-1:0] PH_RESTART       = 5'd17;

    typedef struct packed {
        logic button_level;
        logic stick_up;
        logic stick_down;
        logic stick_left;
        logic stick_right;
    } t_sample;

    typedef struct packed {
        logic [PH_W-1:0] phase_code;
        logic            motor_dir;
        logic            motor_run;
        logic            state_entered;
    } t_result;

    typedef struct packed {
        logic [PH_W-1:0]  phase;
        logic [CNT_W-1:0] edge_elapsed;
        logic [CNT_W-1:0] phase_elapsed;
        logic             prev_button;
        logic             dir;
        logic             run;
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] phase_ticks;
    } t_cfg;

    // Counter increment that stops at the top of its range.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

[design/jsps_sample_if.sv]
// Input channel of the sequencer: one joystick sample per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface jsps_sample_if;
    logic valid;
    logic ready;
    logic button_level;
    logic stick_up;
    logic stick_down;
    logic stick_left;
    logic stick_right;

    modport source (
        output valid, button_level, stick_up, stick_down, stick_left, stick_right,
        input  ready
    );
    modport sink (
        input  valid, button_level, stick_up, stick_down, stick_left, stick_right,
        output ready
    );
endinterface

[design/jsps_result_if.sv]
// Output channel of the sequencer: phase and motor drive per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface jsps_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] phase_code;
    logic       motor_dir;
    logic       motor_run;
    logic       state_entered;

    modport source (
        output valid, phase_code, motor_dir, motor_run, state_entered,
        input  ready
    );
    modport sink (
        input  valid, phase_code, motor_dir, motor_run, state_entered,
        output ready
    );
endinterface

[design/jsps_step.sv]
// Next-state logic of the sequencer for one joystick sample.
// Depends on jsps_pkg.
`timescale 1ns / 1ps

module jsps_step
    import jsps_pkg::*;
(
    input  t_state  i_state,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic            rising;
    logic            press;
    logic            timed_done;
    logic            sampled;
    logic [PH_W-1:0] next_phase;
    logic            next_dir;
    logic            next_run;
    logic            changed;

    // Debounced edge as seen by this sample; only counts where the phase samples it.
    assign rising     = i_sample.button_level && !i_state.prev_button;
    assign press      = rising && (i_state.edge_elapsed >= i_cfg.debounce_ticks);
    assign timed_done = i_state.phase_elapsed >= i_cfg.phase_ticks;

    // Phase transitions and motor drive.
    always_comb begin
        next_phase = i_state.phase;
        next_dir   = i_state.dir;
        next_run   = i_state.run;
        sampled    = 1'b0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_sample.stick_right) begin
                    next_dir = 1'b1;
                    next_run = 1'b1;
                end else if (i_sample.stick_left) begin
                    next_dir = 1'b0;
                    next_run = 1'b1;
                end else begin
                    sampled = 1'b1;
                    if (press) next_phase = PH_PLACEMENT;
                    else next_run = 1'b0;
                end
            end
            PH_PLACEMENT, PH_MEASURE_READY, PH_DISPLAY: begin
                sampled = 1'b1;
                if (press) next_phase = i_state.phase + 1'b1;
            end
            PH_RESTART: begin
                sampled = 1'b1;
                if (press) next_phase = PH_IDLE;
            end
            PH_LOWERING, PH_REMOVAL, PH_SAMPLE_Y, PH_CLEAN_Y, PH_CLEAN_Y2,
            PH_DRY_Y: begin
                if (i_sample.stick_up) begin
                    next_dir = 1'b1;
                    next_run = 1'b1;
                end else if (i_sample.stick_down) begin
                    next_dir = 1'b0;
                    next_run = 1'b1;
                end else begin
                    next_run = 1'b0;
                end
                sampled = 1'b1;
                if (press) next_phase = i_state.phase + 1'b1;
            end
            PH_SAMPLE_X, PH_CLEAN_X, PH_DRY_X: begin
                if (i_sample.stick_left) begin
                    next_dir = 1'b0;
                    next_run = 1'b1;
                end else if (i_sample.stick_right) begin
                    next_dir = 1'b1;
                    next_run = 1'b1;
                end else begin
                    next_run = 1'b0;
                end
                sampled = 1'b1;
                if (press) next_phase = i_state.phase + 1'b1;
            end
            PH_STIRRING: begin
                if (timed_done) begin
                    sampled = 1'b1;
                    if (press) next_phase = PH_MEASURE;
                end
            end
            PH_MEASURE, PH_CLEANING, PH_DRYING: begin
                if (timed_done) next_phase = i_state.phase + 1'b1;
            end
            default: begin
                // Codes past the last phase are never reached and do nothing.
            end
        endcase
    end

    assign changed = (next_phase != i_state.phase);

    // Updated state and the result for this sample.
    always_comb begin
        o_state.phase         = next_phase;
        o_state.dir           = next_dir;
        o_state.run           = next_run;
        o_state.prev_button   = sampled ? i_sample.button_level : i_state.prev_button;
        o_state.edge_elapsed  = (sampled && press) ? CNT_W'(1)
                                                   : sat_inc(i_state.edge_elapsed);
        o_state.phase_elapsed = changed ? CNT_W'(1) : sat_inc(i_state.phase_elapsed);

        o_result.phase_code    = next_phase;
        o_result.motor_dir     = next_dir;
        o_result.motor_run     = next_run;
        o_result.state_entered = changed;
    end

endmodule

[design/joystick_stepper_process_sequencer.sv]
// Top level of the joystick stepper process sequencer.
// Depends on jsps_pkg, jsps_sample_if, jsps_result_if, jsps_step and the macros header.
//
// Usage:
//   i_sample carries one joystick sample per transaction (one per timer tick).
//   o_result returns one transaction per sample: the phase after that tick, the
//   stepper direction and run enable, and a pulse when the phase changed.
//   The configuration port writes debounce_ticks (index 0) or phase_ticks
//   (index 1) at any edge with i_cfg_we high; write it only while no sample
//   is in flight.
// Timing:
//   A sample is captured in the input register; when the result register is
//   free or being taken, the step logic updates the sequencer state and loads
//   the result register, which offers the result. One sample per cycle is
//   sustained while o_result is ready; the single state update per cycle sets that figure.
// Reset:
//   Synchronous, active low. The phase returns to idle, counters and motor
//   drive clear, and the registers return to 50 and 5000 ticks.
// Stall:
//   While o_result is held, the result register keeps its transaction and one
//   more sample waits in the input register; then i_sample.ready drops.
`timescale 1ns / 1ps
`include "joystick_stepper_process_sequencer_macros.svh"

module joystick_stepper_process_sequencer
    import jsps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    jsps_sample_if.sink          i_sample,
    jsps_result_if.source        o_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_result;
    t_sample in_sample;
    logic    out_free;
    logic    step_fire;
    logic    in_accept;

    // Handshake: the input register refills whenever its sample moves on.
    assign out_free       = !r_out_valid || o_result.ready;
    assign step_fire      = r_in_valid && out_free;
    assign i_sample.ready = !r_in_valid || step_fire;
    assign in_accept      = i_sample.valid && i_sample.ready;

    assign in_sample.button_level = i_sample.button_level;
    assign in_sample.stick_up     = i_sample.stick_up;
    assign in_sample.stick_down   = i_sample.stick_down;
    assign in_sample.stick_left   = i_sample.stick_left;
    assign in_sample.stick_right  = i_sample.stick_right;

    jsps_step u_step (
        .i_state  (r_state),
        .i_sample (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Valid flags, sequencer state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state              <= '0;
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.phase_ticks    <= PHASE_TICKS_RESET;
        end else begin
            if (in_accept) r_in_valid <= 1'b1;
            else if (step_fire) r_in_valid <= 1'b0;

            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEBOUNCE:    r_cfg.debounce_ticks <= i_cfg_data;
                    CFG_PHASE_TICKS: r_cfg.phase_ticks    <= i_cfg_data;
                    default:         r_cfg <= r_cfg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) r_in <= in_sample;
        if (step_fire) r_out <= n_result;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.phase_code    = r_out.phase_code;
    assign o_result.motor_dir     = r_out.motor_dir;
    assign o_result.motor_run     = r_out.motor_run;
    assign o_result.state_entered = r_out.state_entered;

    // The phase never leaves the defined sequence.
    `JSPS_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, 1'b1, r_state.phase <= PH_RESTART)
    // A waiting result always matches the state it left behind.
    `JSPS_ASSERT_NOW(a_out_matches_state, i_clk, i_rst_n, r_out_valid,
        (r_out.phase_code == r_state.phase) && (r_out.motor_dir == r_state.dir) &&
        (r_out.motor_run == r_state.run))
    // A phase change restarts the phase counter.
    `JSPS_ASSERT_NOW(a_entered_restarts, i_clk, i_rst_n, r_out_valid && r_out.state_entered,
        r_state.phase_elapsed == CNT_W'(1))
    // Without a step the sequencer state holds.
    `JSPS_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !step_fire && i_rst_n, $stable(r_state))

endmodule

[test/jsps_sequence_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the joystick stepper process sequencer: watches both channels and the
// register port, predicts each tick's phase report and compares it with the block.
// Depends on jsps_pkg, jsps_sample_if and jsps_result_if.

module jsps_sequence_checker
    import jsps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsps_sample_if           i_sample,
    jsps_result_if           i_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output logic [31:0]      o_phases_seen
);

    // Mirror of the sequencer state and its two registers.
    logic [PH_W-1:0]  ph;
    logic [CNT_W-1:0] since_edge;
    logic [CNT_W-1:0] since_entry;
    logic             btn_last;
    logic             drive_dir;
    logic             drive_run;
    logic             press_taken;
    logic [CNT_W-1:0] debounce_limit;
    logic [CNT_W-1:0] phase_limit;

    // Phase reports still owed by the block, oldest first.
    t_result tick_reports[$];

    int          fail_total    = 0;
    int          checked_total = 0;
    logic [31:0] reached       = '0;

    // Tick counters stop at the top of their range.
    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    // Debounced rising-edge detector; only called on ticks that ask for a press.
    function automatic logic accept_press(input logic btn);
        logic rising;
        rising   = btn && !btn_last;
        btn_last = btn;
        if (rising && since_edge >= debounce_limit) begin
            press_taken = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Up/down jog: up wins over down.
    function automatic void jog_updown(input t_sample s);
        if (s.stick_up) begin
            drive_dir = 1'b1;
            drive_run = 1'b1;
        end else if (s.stick_down) begin
            drive_dir = 1'b0;
            drive_run = 1'b1;
        end else begin
            drive_run = 1'b0;
        end
    endfunction

    // Left/right jog: left wins over right.
    function automatic void jog_leftright(input t_sample s);
        if (s.stick_left) begin
            drive_dir = 1'b0;
            drive_run = 1'b1;
        end else if (s.stick_right) begin
            drive_dir = 1'b1;
            drive_run = 1'b1;
        end else begin
            drive_run = 1'b0;
        end
    endfunction

    // One timer tick: updates the mirrored state and returns the phase report.
    function automatic t_result advance_tick(input t_sample s);
        logic [PH_W-1:0] nxt;
        logic            timed_done;
        t_result         r;
        nxt         = ph;
        timed_done  = (since_entry >= phase_limit);
        press_taken = 1'b0;
        case (ph)
            PH_IDLE: begin
                // In idle a jog beats the button, and right beats left.
                if (s.stick_right) begin
                    drive_dir = 1'b1;
                    drive_run = 1'b1;
                end else if (s.stick_left) begin
                    drive_dir = 1'b0;
                    drive_run = 1'b1;
                end else if (accept_press(s.button_level)) begin
                    nxt = PH_PLACEMENT;
                end else begin
                    drive_run = 1'b0;
                end
            end
            PH_PLACEMENT, PH_MEASURE_READY, PH_DISPLAY: begin
                if (accept_press(s.button_level)) nxt = ph + 5'd1;
            end
            PH_RESTART: begin
                if (accept_press(s.button_level)) nxt = PH_IDLE;
            end
            PH_LOWERING, PH_REMOVAL, PH_SAMPLE_Y, PH_CLEAN_Y, PH_CLEAN_Y2, PH_DRY_Y: begin
                jog_updown(s);
                if (accept_press(s.button_level)) nxt = ph + 5'd1;
            end
            PH_SAMPLE_X, PH_CLEAN_X, PH_DRY_X: begin
                jog_leftright(s);
                if (accept_press(s.button_level)) nxt = ph + 5'd1;
            end
            PH_STIRRING: begin
                // The button is only looked at once the stirring time is over.
                if (timed_done) begin
                    if (accept_press(s.button_level)) nxt = PH_MEASURE;
                end
            end
            PH_MEASURE, PH_CLEANING, PH_DRYING: begin
                if (timed_done) nxt = ph + 5'd1;
            end
            default: begin
            end
        endcase
        r.state_entered = (nxt != ph);
        ph              = nxt;
        since_edge      = press_taken ? 16'd1 : count_up(since_edge);
        since_entry     = r.state_entered ? 16'd1 : count_up(since_entry);
        r.phase_code    = ph;
        r.motor_dir     = drive_dir;
        r.motor_run     = drive_run;
        return r;
    endfunction

    // Per edge: retire a result transaction, apply register writes, then predict
    // the report of a newly accepted sample transaction.
    always @(posedge i_clk) begin
        t_sample smp;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ph             = PH_IDLE;
            since_edge     = '0;
            since_entry    = '0;
            btn_last       = 1'b0;
            drive_dir      = 1'b0;
            drive_run      = 1'b0;
            debounce_limit = DEBOUNCE_RESET;
            phase_limit    = PHASE_TICKS_RESET;
            tick_reports.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.phase_code    = i_result.phase_code;
                got.motor_dir     = i_result.motor_dir;
                got.motor_run     = i_result.motor_run;
                got.state_entered = i_result.state_entered;
                if (tick_reports.size() == 0) begin
                    $error("unexpected result: phase_code %0d with no sample outstanding",
                           got.phase_code);
                    fail_total++;
                end else begin
                    want = tick_reports.pop_front();
                    if (got.phase_code !== want.phase_code) begin
                        $error("phase_code mismatch: expected %0d, actual %0d",
                               want.phase_code, got.phase_code);
                        fail_total++;
                    end
                    if (got.motor_dir !== want.motor_dir) begin
                        $error("motor_dir mismatch: expected %0b, actual %0b",
                               want.motor_dir, got.motor_dir);
                        fail_total++;
                    end
                    if (got.motor_run !== want.motor_run) begin
                        $error("motor_run mismatch: expected %0b, actual %0b",
                               want.motor_run, got.motor_run);
                        fail_total++;
                    end
                    if (got.state_entered !== want.state_entered) begin
                        $error("state_entered mismatch: expected %0b, actual %0b",
                               want.state_entered, got.state_entered);
                        fail_total++;
                    end
                    checked_total++;
                    reached[want.phase_code] = 1'b1;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEBOUNCE) debounce_limit = i_cfg_data;
                else if (i_cfg_idx == CFG_PHASE_TICKS) phase_limit = i_cfg_data;
            end
            if (i_sample.valid && i_sample.ready) begin
                smp.button_level = i_sample.button_level;
                smp.stick_up     = i_sample.stick_up;
                smp.stick_down   = i_sample.stick_down;
                smp.stick_left   = i_sample.stick_left;
                smp.stick_right  = i_sample.stick_right;
                tick_reports.push_back(advance_tick(smp));
            end
        end
        o_fail_count  <= fail_total;
        o_pending     <= tick_reports.size();
        o_checked     <= checked_total;
        o_phases_seen <= reached;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the sequencer testbench: clock, reset, register writes and joystick stimulus
// with random idling on both channels, plus the verdict. Depends on jsps_pkg, the
// channel interfaces, the sequencer and jsps_sequence_checker.

module testbench;
    import jsps_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SOAK_SAMPLES  = 120;
    localparam int RANDOM_ROUNDS = 6;
    localparam int ROUND_SAMPLES = 140;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CNT_W-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    logic [31:0] phases_seen;

    // Stimulus controls; idle_on and hold_armed are shared by the sender and the receiver.
    bit   idle_on          = 1'b1;
    bit   hold_armed       = 1'b0;
    logic btn_level        = 1'b0;
    int   btn_hold         = 0;
    int   press_span       = 3;
    int   samples_sent     = 0;
    int   settings_written = 0;
    int   quiet_cycles     = 0;

    jsps_sample_if smp_if();
    jsps_result_if res_if();

    joystick_stepper_process_sequencer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    jsps_sequence_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_sample      (smp_if),
        .i_result      (res_if),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_phases_seen (phases_seen)
    );

    // 8 ns clock.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Offers one sample transaction after a random gap and waits for its acceptance.
    // Valid stays high afterwards so back-to-back samples need no second assignment.
    task automatic send_sample(input t_sample s);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.button_level <= s.button_level;
        smp_if.stick_up     <= s.stick_up;
        smp_if.stick_down   <= s.stick_down;
        smp_if.stick_left   <= s.stick_left;
        smp_if.stick_right  <= s.stick_right;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_joy(input logic b, input logic u, input logic d,
                            input logic l, input logic r);
        t_sample s;
        s.button_level = b;
        s.stick_up     = u;
        s.stick_down   = d;
        s.stick_left   = l;
        s.stick_right  = r;
        send_sample(s);
    endtask

    // Stops offering samples and waits until every result has come back.
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes both registers, debounce first and then the phase ticks; only called while the block is idle.
    task automatic write_settings(input logic [CNT_W-1:0] debounce,
                                  input logic [CNT_W-1:0] span);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DEBOUNCE;
        cfg_data <= debounce;
        @(posedge clk);
        cfg_idx  <= CFG_PHASE_TICKS;
        cfg_data <= span;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    // Mostly clean press and release runs with random stick deflections; one sample
    // in five is pure noise.
    function automatic t_sample draw_sample();
        t_sample s;
        if ($urandom_range(0, 4) == 0) begin
            s = t_sample'(5'($urandom_range(0, 31)));
        end else begin
            if (btn_hold == 0) begin
                btn_level = ~btn_level;
                btn_hold  = $urandom_range(1, press_span);
            end else begin
                btn_hold--;
            end
            s.button_level = btn_level;
            s.stick_up     = ($urandom_range(0, 3) == 0);
            s.stick_down   = ($urandom_range(0, 3) == 0);
            s.stick_left   = ($urandom_range(0, 3) == 0);
            s.stick_right  = ($urandom_range(0, 3) == 0);
        end
        return s;
    endfunction

    // Result receiver: random stalls, plus one long hold per random round so that
    // the block fills up and pushes back on its input.
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_armed) begin
                hold_armed = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = idle_on ? $urandom_range(0, 3) : 0;
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] span;
        int               soak_count;
        smp_if.valid        <= 1'b0;
        smp_if.button_level <= 1'b0;
        smp_if.stick_up     <= 1'b0;
        smp_if.stick_down   <= 1'b0;
        smp_if.stick_left   <= 1'b0;
        smp_if.stick_right  <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_DEBOUNCE;
        cfg_data            <= '0;
        rst_n               <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: right beats left in idle, a press inside the debounce window.
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_joy(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        drain();

        // Zero limits: every edge counts and timed phases end on their first tick.
        write_settings(16'd0, 16'd0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        // Lowering: up beats down, then down alone, then stop and press.
        send_joy(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        // Stirring, then measurement, which moves on by itself.
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        // The held button was not sampled in measurement, so it needs a release first.
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        // Sample X move: left beats right, then right alone with a press.
        send_joy(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_joy(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        drain();

        // Full-scale limits with no idling: presses stay inside the debounce window
        // and the timed phases do not run out, so only the jog drive moves.
        write_settings(CNT_MAX, CNT_MAX);
        idle_on    = 1'b0;
        press_span = 3;
        soak_count = samples_sent;
        repeat (SOAK_SAMPLES) send_sample(draw_sample());
        soak_count = samples_sent - soak_count;
        drain();
        idle_on = 1'b1;

        // Random rounds with short limits so the sequence wraps around many times.
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            if (round == 0) begin
                debounce = '0;
                span     = '0;
            end else begin
                debounce = 16'($urandom_range(0, 4));
                span     = 16'($urandom_range(0, 12));
            end
            write_settings(debounce, span);
            press_span = int'(debounce) + 2;
            hold_armed = 1'b1;
            repeat (ROUND_SAMPLES) send_sample(draw_sample());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run: %0d samples (%0d at full-scale limits) over %0d register settings",
                 samples_sent, soak_count, settings_written);
        $display("Run: %0d results compared, phases reached %b", checked, phases_seen[17:0]);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/jsps_pkg.sv
design/jsps_sample_if.sv
design/jsps_result_if.sv
design/jsps_step.sv
design/joystick_stepper_process_sequencer.sv
test/jsps_sequence_checker.sv
test/testbench.sv
